/* src/rpv_pkg.sv */
// Shared widths, constants, types and a rounding helper of the revolve profile vertex block.
package rpv_pkg;

  localparam int STEP_W    = 10;
  localparam int POINT_W   = 10;
  localparam int COORD_W   = 16;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int INDEX_W   = 20;
  localparam int STATUS_W  = 2;

  localparam int MAX_STEPS  = 1024;
  localparam int MAX_POINTS = 1024;

  localparam logic [CFG_W-1:0] ROT_STEPS_RESET = CFG_W'(16);
  localparam logic [CFG_W-1:0] PROF_COUNT_RESET = CFG_W'(16);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_STEPS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PROFILE_COUNT  = CFG_IDX_W'(1);

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK          = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_ZERO_NORMAL = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_BAD_STEP    = STATUS_W'(2);

  // Quadrant codes of the angle reduction.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Angle path.
  localparam int THETA_W      = 32;
  localparam int DIV_BITS     = 2;
  localparam int DIV_STAGES   = THETA_W / DIV_BITS;
  localparam int CORDIC_ITERS = 16;
  localparam int TRIG_W       = 34;
  localparam logic signed [TRIG_W-1:0] INV_GAIN_Q30 = TRIG_W'(652032874);
  localparam logic signed [TRIG_W-1:0] ATAN_TURN [CORDIC_ITERS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667332, 34'sd21354465, 34'sd10679839, 34'sd5340245,
    34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
    34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861
  };

  // Normal path.
  localparam int R2_W        = 32;
  localparam int ROOT_W      = 30;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int QUO_W       = 32;
  localparam int UNIT_W      = 32;

  // Stage counts after the input register.
  localparam int ANGLE_LAT = DIV_STAGES + 1 + CORDIC_ITERS;
  localparam int NORM_LAT  = 1 + SQRT_STAGES + QUO_W;
  localparam int CS_DELAY  = NORM_LAT - ANGLE_LAT;
  localparam int PIPE_LAST = NORM_LAT + 1;

  localparam int WIDE_W = 66;

  typedef struct packed {
    logic [INDEX_W-1:0]        vertex_index;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      bad_step;
    logic                      zero_normal;
  } side_t;

  typedef struct packed {
    logic [COORD_W-1:0] mag_x;
    logic [COORD_W-1:0] mag_y;
    logic               neg_x;
    logic               neg_y;
  } norm_side_t;

  // Round half up after an arithmetic right shift, then saturate to 16 bits.
  function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [WIDE_W-1:0] v,
                                                         input int sh);
    logic signed [WIDE_W-1:0] t;
    t = (v + (WIDE_W'(1) <<< (sh - 1))) >>> sh;
    if (t > WIDE_W'(32767)) return 16'sh7FFF;
    if (t < -WIDE_W'(32768)) return 16'sh8000;
    return COORD_W'(t);
  endfunction

endpackage

/* src/rpv_angle.sv */
// Angle path: step over steps as a turn fraction, quadrant reduction and a CORDIC pipeline.
module rpv_angle (
  input  logic                               clk,
  input  logic                               en,
  input  logic [rpv_pkg::STEP_W-1:0]         step,
  input  logic [rpv_pkg::CFG_W-1:0]          rot_steps,
  output logic signed [rpv_pkg::UNIT_W-1:0]  cos_val,
  output logic signed [rpv_pkg::UNIT_W-1:0]  sin_val
);
  import rpv_pkg::*;

  logic [CFG_W-1:0]   rem_r [DIV_STAGES];
  logic [THETA_W-1:0] quo_r [DIV_STAGES];

  logic [1:0]               quad_r;
  logic signed [TRIG_W-1:0] z0_r;

  logic signed [TRIG_W-1:0] x_r [CORDIC_ITERS];
  logic signed [TRIG_W-1:0] y_r [CORDIC_ITERS];
  logic signed [TRIG_W-1:0] z_r [CORDIC_ITERS];
  logic [1:0]               q_r [CORDIC_ITERS];

  // Long division of step * 2^32 by the step count, two quotient bits a stage.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic [CFG_W-1:0]   r_in;
    logic [THETA_W-1:0] q_in;
    logic [CFG_W:0]     t0, t1;
    logic [CFG_W-1:0]   r_mid, r_out;
    logic               b0, b1;
    if (g == 0) begin : g_first
      assign r_in = CFG_W'(step);
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_r[g-1];
      assign q_in = quo_r[g-1];
    end
    always_comb begin
      t0    = {r_in, 1'b0};
      b0    = t0 >= {1'b0, rot_steps};
      r_mid = b0 ? CFG_W'(t0 - {1'b0, rot_steps}) : CFG_W'(t0);
      t1    = {r_mid, 1'b0};
      b1    = t1 >= {1'b0, rot_steps};
      r_out = b1 ? CFG_W'(t1 - {1'b0, rot_steps}) : CFG_W'(t1);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= r_out;
        quo_r[g] <= {q_in[THETA_W-DIV_BITS-1:0], b0, b1};
      end
    end
  end

  // Nearest quadrant and a residual of at most an eighth of a turn.
  logic [THETA_W:0]   theta_sum;
  logic [1:0]         quad;
  logic [THETA_W-1:0] resid;
  always_comb begin
    theta_sum = {1'b0, quo_r[DIV_STAGES-1]} + (THETA_W+1)'(1 << 29);
    quad      = theta_sum[31:30];
    resid     = quo_r[DIV_STAGES-1] - {quad, 30'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad_r <= quad;
      z0_r   <= TRIG_W'(signed'(resid));
    end
  end

  for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cordic
    logic signed [TRIG_W-1:0] x_in, y_in, z_in;
    logic [1:0]               q_in;
    if (g == 0) begin : g_first
      assign x_in = INV_GAIN_Q30;
      assign y_in = '0;
      assign z_in = z0_r;
      assign q_in = quad_r;
    end else begin : g_next
      assign x_in = x_r[g-1];
      assign y_in = y_r[g-1];
      assign z_in = z_r[g-1];
      assign q_in = q_r[g-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[g] <= q_in;
        if (!z_in[TRIG_W-1]) begin
          x_r[g] <= x_in - (y_in >>> g);
          y_r[g] <= y_in + (x_in >>> g);
          z_r[g] <= z_in - ATAN_TURN[g];
        end else begin
          x_r[g] <= x_in + (y_in >>> g);
          y_r[g] <= y_in - (x_in >>> g);
          z_r[g] <= z_in + ATAN_TURN[g];
        end
      end
    end
  end

  logic signed [TRIG_W-1:0] xf, yf;
  assign xf = x_r[CORDIC_ITERS-1];
  assign yf = y_r[CORDIC_ITERS-1];

  always_comb begin
    case (q_r[CORDIC_ITERS-1])
      QUAD_0: begin
        cos_val = UNIT_W'(xf);
        sin_val = UNIT_W'(yf);
      end
      QUAD_1: begin
        cos_val = UNIT_W'(-yf);
        sin_val = UNIT_W'(xf);
      end
      QUAD_2: begin
        cos_val = UNIT_W'(-xf);
        sin_val = UNIT_W'(-yf);
      end
      default: begin
        cos_val = UNIT_W'(yf);
        sin_val = UNIT_W'(-xf);
      end
    endcase
  end

endmodule

/* src/rpv_unit_normal.sv */
// Normal path: squared length, pipelined square root and two pipelined dividers.
module rpv_unit_normal (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [rpv_pkg::COORD_W-1:0] nx,
  input  logic signed [rpv_pkg::COORD_W-1:0] ny,
  output logic signed [rpv_pkg::UNIT_W-1:0]  unit_x,
  output logic signed [rpv_pkg::UNIT_W-1:0]  unit_y
);
  import rpv_pkg::*;

  logic [COORD_W-1:0] mag_x, mag_y;
  logic [R2_W-1:0]    r2_r;
  norm_side_t         side_r;

  logic [R2_W-1:0]   sq_r2   [SQRT_STAGES];
  logic [R2_W-1:0]   sq_rem  [SQRT_STAGES];
  logic [ROOT_W-1:0] sq_root [SQRT_STAGES];
  norm_side_t        sq_side [SQRT_STAGES];

  logic [ROOT_W-1:0] dv_s    [QUO_W];
  logic [ROOT_W-1:0] dv_rx   [QUO_W];
  logic [ROOT_W-1:0] dv_ry   [QUO_W];
  logic [QUO_W-1:0]  dv_qx   [QUO_W];
  logic [QUO_W-1:0]  dv_qy   [QUO_W];
  norm_side_t        dv_side [QUO_W];

  assign mag_x = nx[COORD_W-1] ? COORD_W'(-nx) : COORD_W'(nx);
  assign mag_y = ny[COORD_W-1] ? COORD_W'(-ny) : COORD_W'(ny);

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r         <= R2_W'(mag_x) * R2_W'(mag_x) + R2_W'(mag_y) * R2_W'(mag_y);
      side_r.mag_x <= mag_x;
      side_r.mag_y <= mag_y;
      side_r.neg_x <= nx[COORD_W-1];
      side_r.neg_y <= ny[COORD_W-1];
    end
  end

  // Digit-by-digit root of r2 * 2^28, one root bit a stage. The low 28 bits
  // of that operand are zero, so later stages bring in zero pairs.
  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    logic [R2_W-1:0]   r2_in, rem_in;
    logic [ROOT_W-1:0] root_in;
    norm_side_t        side_in;
    logic [1:0]        pair;
    logic [R2_W+1:0]   t;
    logic [R2_W+1:0]   trial;
    logic              ge;
    if (g == 0) begin : g_first
      assign r2_in   = r2_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_r;
    end else begin : g_next
      assign r2_in   = sq_r2[g-1];
      assign rem_in  = sq_rem[g-1];
      assign root_in = sq_root[g-1];
      assign side_in = sq_side[g-1];
    end
    if (2 * g + 1 < R2_W) begin : g_pair
      assign pair = r2_in[R2_W-1-2*g -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end
    always_comb begin
      t     = {rem_in, pair};
      trial = (R2_W+2)'({root_in, 2'b01});
      ge    = t >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r2[g]   <= r2_in;
        sq_rem[g]  <= ge ? R2_W'(t - trial) : R2_W'(t);
        sq_root[g] <= {root_in[ROOT_W-2:0], ge};
        sq_side[g] <= side_in;
      end
    end
  end

  // Restoring division of (m * 2^44 + s/2) by s, one quotient bit a stage.
  // The upper part m * 2^12 is already below s, so it seeds the remainder.
  for (genvar g = 0; g < QUO_W; g++) begin : g_qdiv
    logic [ROOT_W-1:0] s_in, rx_in, ry_in;
    logic [QUO_W-1:0]  qx_in, qy_in;
    norm_side_t        side_in;
    logic [QUO_W-1:0]  half;
    logic [ROOT_W:0]   tx, ty;
    logic              gex, gey;
    if (g == 0) begin : g_first
      assign s_in    = sq_root[SQRT_STAGES-1];
      assign side_in = sq_side[SQRT_STAGES-1];
      assign rx_in   = ROOT_W'({side_in.mag_x, 12'b0});
      assign ry_in   = ROOT_W'({side_in.mag_y, 12'b0});
      assign qx_in   = '0;
      assign qy_in   = '0;
    end else begin : g_next
      assign s_in    = dv_s[g-1];
      assign side_in = dv_side[g-1];
      assign rx_in   = dv_rx[g-1];
      assign ry_in   = dv_ry[g-1];
      assign qx_in   = dv_qx[g-1];
      assign qy_in   = dv_qy[g-1];
    end
    always_comb begin
      half = QUO_W'(s_in >> 1);
      tx   = {rx_in, half[QUO_W-1-g]};
      ty   = {ry_in, half[QUO_W-1-g]};
      gex  = tx >= {1'b0, s_in};
      gey  = ty >= {1'b0, s_in};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_s[g]    <= s_in;
        dv_side[g] <= side_in;
        dv_rx[g]   <= gex ? ROOT_W'(tx - {1'b0, s_in}) : ROOT_W'(tx);
        dv_ry[g]   <= gey ? ROOT_W'(ty - {1'b0, s_in}) : ROOT_W'(ty);
        dv_qx[g]   <= {qx_in[QUO_W-2:0], gex};
        dv_qy[g]   <= {qy_in[QUO_W-2:0], gey};
      end
    end
  end

  assign unit_x = dv_side[QUO_W-1].neg_x ? -UNIT_W'(signed'(dv_qx[QUO_W-1]))
                                         : UNIT_W'(signed'(dv_qx[QUO_W-1]));
  assign unit_y = dv_side[QUO_W-1].neg_y ? -UNIT_W'(signed'(dv_qy[QUO_W-1]))
                                         : UNIT_W'(signed'(dv_qy[QUO_W-1]));

endmodule

/* src/revolve_profile_vertex_top.sv */
// Top level of the revolve profile vertex block: configuration, pipeline control and output.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | step_index, point_index, profile_x/y, normal_x/y
//   out     | output    | out_valid / out_ready | vertex_index, out_x/y/z, out_normal_x/y/z, status
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item enters per cycle while in_ready is high.
// The latency is set by the normal path: a 30-stage square root and a 32-stage divider.
// All stages advance together and stall only while the last stage holds an item that
// the output register cannot take. Reset clears the valid bits and sets both step
// and point counts to 16. The cfg channel is always ready.
module revolve_profile_vertex_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [rpv_pkg::STEP_W-1:0]            step_index,
  input  logic [rpv_pkg::POINT_W-1:0]           point_index,
  input  logic signed [rpv_pkg::COORD_W-1:0]    profile_x,
  input  logic signed [rpv_pkg::COORD_W-1:0]    profile_y,
  input  logic signed [rpv_pkg::COORD_W-1:0]    normal_x,
  input  logic signed [rpv_pkg::COORD_W-1:0]    normal_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [rpv_pkg::INDEX_W-1:0]           vertex_index,
  output logic signed [rpv_pkg::COORD_W-1:0]    out_x,
  output logic signed [rpv_pkg::COORD_W-1:0]    out_y,
  output logic signed [rpv_pkg::COORD_W-1:0]    out_z,
  output logic signed [rpv_pkg::COORD_W-1:0]    out_normal_x,
  output logic signed [rpv_pkg::COORD_W-1:0]    out_normal_y,
  output logic signed [rpv_pkg::COORD_W-1:0]    out_normal_z,
  output logic [rpv_pkg::STATUS_W-1:0]          status,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rpv_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rpv_pkg::CFG_W-1:0]             cfg_data
);
  import rpv_pkg::*;

  logic [CFG_W-1:0] rotation_steps, profile_count;

  logic [PIPE_LAST:0] vld;
  logic               en;
  logic               out_load;

  logic [STEP_W-1:0]         st_step;
  logic signed [COORD_W-1:0] st_nx, st_ny;
  side_t                     side_pipe [NORM_LAT+1];

  logic signed [UNIT_W-1:0] cos_a, sin_a, unit_x, unit_y;
  logic signed [UNIT_W-1:0] cos_d [CS_DELAY];
  logic signed [UNIT_W-1:0] sin_d [CS_DELAY];

  logic signed [COORD_W+UNIT_W-1:0] prod_xc, prod_xs;
  logic signed [2*UNIT_W-1:0]       prod_nc, prod_ns;
  logic signed [UNIT_W-1:0]         my_r;
  side_t                            side_r;

  logic [CFG_W-1:0]   count;
  logic               bad_step;
  side_t              side_in;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_steps <= ROT_STEPS_RESET;
      profile_count  <= PROF_COUNT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROTATION_STEPS: rotation_steps <= cfg_data;
        REG_PROFILE_COUNT:  profile_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !vld[PIPE_LAST] || !out_valid || out_ready;
  assign in_ready = en;
  assign out_load = vld[PIPE_LAST] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAST-1:0], in_valid};
    end
  end

  always_comb begin
    count    = (32'(profile_count) > MAX_POINTS) ? CFG_W'(MAX_POINTS) : profile_count;
    bad_step = (rotation_steps == '0) || (32'(rotation_steps) > MAX_STEPS)
               || ({1'b0, step_index} >= rotation_steps);
    side_in.vertex_index = INDEX_W'(step_index * count + (STEP_W+CFG_W)'(point_index));
    side_in.px           = profile_x;
    side_in.py           = profile_y;
    side_in.bad_step     = bad_step;
    side_in.zero_normal  = (normal_x == '0) && (normal_y == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_step      <= step_index;
      st_nx        <= normal_x;
      st_ny        <= normal_y;
      side_pipe[0] <= side_in;
      for (int i = 1; i <= NORM_LAT; i++) begin
        side_pipe[i] <= side_pipe[i-1];
      end
    end
  end

  rpv_angle u_angle (
    .clk       (clk),
    .en        (en),
    .step      (st_step),
    .rot_steps (rotation_steps),
    .cos_val   (cos_a),
    .sin_val   (sin_a)
  );

  rpv_unit_normal u_normal (
    .clk    (clk),
    .en     (en),
    .nx     (st_nx),
    .ny     (st_ny),
    .unit_x (unit_x),
    .unit_y (unit_y)
  );

  // The angle finishes earlier than the normal; hold its result back to match.
  always_ff @(posedge clk) begin
    if (en) begin
      cos_d[0] <= cos_a;
      sin_d[0] <= sin_a;
      for (int i = 1; i < CS_DELAY; i++) begin
        cos_d[i] <= cos_d[i-1];
        sin_d[i] <= sin_d[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_xc <= side_pipe[NORM_LAT].px * cos_d[CS_DELAY-1];
      prod_xs <= side_pipe[NORM_LAT].px * sin_d[CS_DELAY-1];
      prod_nc <= unit_x * cos_d[CS_DELAY-1];
      prod_ns <= unit_x * sin_d[CS_DELAY-1];
      my_r    <= unit_y;
      side_r  <= side_pipe[NORM_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (side_r.bad_step) begin
        vertex_index <= '0;
        out_x        <= '0;
        out_y        <= '0;
        out_z        <= '0;
        out_normal_x <= '0;
        out_normal_y <= '0;
        out_normal_z <= '0;
        status       <= STATUS_BAD_STEP;
      end else begin
        vertex_index <= side_r.vertex_index;
        out_x        <= round_sat(WIDE_W'(prod_xc), 30);
        out_y        <= side_r.py;
        out_z        <= round_sat(-WIDE_W'(prod_xs), 30);
        if (side_r.zero_normal) begin
          out_normal_x <= '0;
          out_normal_y <= '0;
          out_normal_z <= '0;
          status       <= STATUS_ZERO_NORMAL;
        end else begin
          out_normal_x <= round_sat(-WIDE_W'(prod_nc), 46);
          out_normal_y <= round_sat(-WIDE_W'(my_r), 16);
          out_normal_z <= round_sat(WIDE_W'(prod_ns), 46);
          status       <= STATUS_OK;
        end
      end
    end
  end

endmodule
